[src/spt_pkg.sv]
// Shared types, codes and constants for the sweep pulse timing decoder.
`default_nettype none
package spt_pkg;

  localparam int MAX_SENSORS_DEF = 8;
  localparam int TS_W            = 32;
  localparam int CENTRE_W        = 21;  // base (20b) + 7 * step (16b) fits here
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 24;

  localparam logic [TS_W:0] ACCEPT_MARGIN = 33'd10000;
  localparam logic [7:0]    FRAME_MARK    = 8'hff;
  localparam logic [7:0]    ID_OFFSET     = 8'd2;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_BASE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_STEP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WIDTH   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_PERIOD = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SENSOR_COUNT = 3'd4;

  localparam logic [19:0] SYNC_BASE_RST    = 20'd6000;
  localparam logic [15:0] SYNC_STEP_RST    = 16'd1000;
  localparam logic [15:0] HALF_WIDTH_RST   = 16'd500;
  localparam logic [23:0] SWEEP_PERIOD_RST = 24'd800000;
  localparam logic [3:0]  SENSOR_COUNT_RST = 4'd8;

  // pulse classes
  localparam logic [1:0] PT_START   = 2'd0;
  localparam logic [1:0] PT_SYNC    = 2'd1;
  localparam logic [1:0] PT_SWEEP   = 2'd2;
  localparam logic [1:0] PT_OUTLIER = 2'd3;

  // item kinds
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [2:0]      sensor_index;
    logic            level;
    logic [TS_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] pulse_type;
    logic       skip_bit;
    logic       rotor_bit;
    logic       data_bit;
    logic [7:0] frame_byte;
    logic       last;
  } out_item_t;

  // classifier result toward the control logic
  typedef struct packed {
    logic       done;
    logic [1:0] ptype;
    logic [2:0] code;
  } cls_res_t;

endpackage
`default_nettype wire

[src/spt_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module spt_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/spt_classifier.sv]
// Iterative pulse width classifier: walks the eight sync windows, one a cycle.
`default_nettype none
module spt_classifier
  import spt_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [TS_W-1:0] len,
  input  wire logic [19:0]     base,
  input  wire logic [15:0]     step,
  input  wire logic [15:0]     half,
  output cls_res_t             res
);

  logic                busy_r;
  logic [2:0]          k_r;
  logic [CENTRE_W-1:0] centre_r;
  logic [TS_W-1:0]     len_r;
  logic [TS_W:0]       lh_r;      // len + half, so the low bound needs no sign
  logic [CENTRE_W:0]   upper;
  logic                hit;

  // window is [centre - half, centre + half)
  assign upper = {1'b0, centre_r} + (CENTRE_W + 1)'(half);
  assign hit   = (lh_r >= (TS_W + 1)'(centre_r)) && ({1'b0, len_r} < (TS_W + 1)'(upper));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (res.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r      <= '0;
      centre_r <= CENTRE_W'(base);
      len_r    <= len;
      lh_r     <= {1'b0, len} + (TS_W + 1)'(half);
    end else if (busy_r) begin
      k_r      <= k_r + 3'd1;
      centre_r <= centre_r + CENTRE_W'(step);
    end
  end

  always_comb begin
    res.done  = busy_r && (hit || (k_r == 3'd7));
    res.code  = hit ? k_r : 3'd0;
    if (hit) begin
      res.ptype = PT_SYNC;
    end else if (lh_r < (TS_W + 1)'(base)) begin
      res.ptype = PT_SWEEP;
    end else begin
      res.ptype = PT_OUTLIER;
    end
  end

`ifndef ASSERT_OFF
  a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> busy_r)
    else $error("classifier done while idle");
  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !res.done) |-> !start)
    else $error("classifier restarted mid-search");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res.done && !start) |=> !busy_r)
    else $error("classifier stays busy after done");
`endif

endmodule
`default_nettype wire

[src/sweep_pulse_timing_decoder_top.sv]
// Top level of the sweep pulse timing decoder: control, state and memories.
// Rising edge: the start result is loaded into the result register as the item is taken;
//   falling edge: RAM read, width compute, 1 to 8 window checks in the classifier, result load.
// Frame request: 3 header bytes, then for each marked sensor a RAM read + 5 bytes.
// One item in flight; the next item is taken the cycle after its last result is loaded.
// rst_n (sync, active low) clears control, config and the start/mark valid bits;
//   delay RAM contents are not cleared and need no clearing pass.
`default_nettype none
module sweep_pulse_timing_decoder_top
  import spt_pkg::*;
#(
  parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LEN  = 7'b0000010,  // start time arrives from RAM, width computed
    ST_CLS  = 7'b0000100,  // classifier walks windows
    ST_EMIT = 7'b0001000,  // pulse result waits for the output register
    ST_FHDR = 7'b0010000,  // frame marks and meta byte
    ST_FSEL = 7'b0100000,  // pick next marked sensor, read its delay
    ST_FDAT = 7'b1000000   // id byte and four delay bytes
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [19:0] base_r;
  logic [15:0] step_r;
  logic [15:0] half_r;
  logic [23:0] period_r;
  logic [3:0]  count_r;

  // per-item context
  in_item_t         item_r;
  logic [IDX_W-1:0] sidx_r;
  logic [TS_W-1:0]  start_r;
  logic [TS_W-1:0]  delay_r;
  out_item_t        res_r;

  // sync tracking
  logic [2:0]      latest_r;
  logic [2:0]      prev_r;
  logic [TS_W-1:0] sync_start_r;
  logic            armed_r;
  logic [7:0]      run_r;
  logic            station_r;

  // per-sensor flags (flops); start times and delays in RAM
  logic [MAX_SENSORS-1:0] edge_vld_r;
  logic [MAX_SENSORS-1:0] seen_r;
  logic [MAX_SENSORS-1:0] pend_r;
  logic [MAX_SENSORS-1:0] pend_clr;
  logic [MAX_SENSORS-1:0] nmask;
  logic [IDX_W-1:0]       sel_r;
  logic [IDX_W-1:0]       first_idx;
  logic [2:0]             bcnt_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      out_load;
  out_item_t out_nxt;

  logic             in_acc;
  logic             in_ok;
  logic [IDX_W-1:0] in_sidx;
  logic [TS_W-1:0]  edge_rdata;
  logic [TS_W-1:0]  delay_rdata;
  logic [TS_W-1:0]  start_val;
  logic [TS_W-1:0]  len_val;
  cls_res_t         cls;
  logic             sweep_take;
  logic             frame_end;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_sidx   = IDX_W'(in_data.sensor_index);
  // indexes past the sensor array are dropped without a result
  assign in_ok     = ({1'b0, in_data.sensor_index} < 4'(MAX_SENSORS));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // sensors below the configured count; counts above the array clamp naturally
  always_comb begin
    for (int i = 0; i < MAX_SENSORS; i++) begin
      nmask[i] = (4'(i) < count_r);
    end
  end

  // lowest pending sensor of the frame
  always_comb begin
    first_idx = '0;
    for (int i = MAX_SENSORS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    pend_clr         = pend_r;
    pend_clr[sel_r]  = 1'b0;
  end

  // ---------------------------------------------------------------- memories
  spt_ram #(.DEPTH(MAX_SENSORS), .WIDTH(TS_W)) u_edge_ram (
    .clk   (clk),
    .we    (in_acc && (in_data.kind == KIND_EDGE) && in_ok && in_data.level),
    .waddr (in_sidx),
    .wdata (in_data.timestamp),
    .re    (in_acc && (in_data.kind == KIND_EDGE) && in_ok && !in_data.level),
    .raddr (in_sidx),
    .rdata (edge_rdata)
  );

  spt_ram #(.DEPTH(MAX_SENSORS), .WIDTH(TS_W)) u_delay_ram (
    .clk   (clk),
    .we    (sweep_take),
    .waddr (sidx_r),
    .wdata (delay_r),
    .re    (state_r == ST_FSEL),
    .raddr (first_idx),
    .rdata (delay_rdata)
  );

  // never-written start entries read as zero
  assign start_val = edge_vld_r[sidx_r] ? edge_rdata : '0;
  assign len_val   = item_r.timestamp - start_val;

  spt_classifier u_cls (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_LEN),
    .len   (len_val),
    .base  (base_r),
    .step  (step_r),
    .half  (half_r),
    .res   (cls)
  );

  // sweep accepted: unmarked sensor, armed, delay + margin below period
  assign sweep_take = (state_r == ST_CLS) && cls.done && (cls.ptype == PT_SWEEP) &&
                      !seen_r[sidx_r] && armed_r &&
                      (({1'b0, delay_r} + ACCEPT_MARGIN) < (TS_W + 1)'(period_r));

  // --------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= SYNC_BASE_RST;
      step_r   <= SYNC_STEP_RST;
      half_r   <= HALF_WIDTH_RST;
      period_r <= SWEEP_PERIOD_RST;
      count_r  <= SENSOR_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SYNC_BASE:    base_r   <= cfg_wdata[19:0];
        CFG_SYNC_STEP:    step_r   <= cfg_wdata[15:0];
        CFG_HALF_WIDTH:   half_r   <= cfg_wdata[15:0];
        CFG_SWEEP_PERIOD: period_r <= cfg_wdata[23:0];
        CFG_SENSOR_COUNT: count_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- output byte mux
  always_comb begin
    out_nxt = '0;
    out_load = 1'b0;
    frame_end = 1'b0;
    unique case (state_r)
      ST_EMIT: begin
        out_nxt  = res_r;
        out_load = out_free;
      end
      ST_FHDR: begin
        out_nxt.result_kind = 1'b1;
        out_nxt.frame_byte  = (bcnt_r == 3'd2) ? {4'd0, station_r, prev_r} : FRAME_MARK;
        out_nxt.last        = (bcnt_r == 3'd2) && (pend_r == '0);
        out_load            = out_free;
        frame_end           = out_free && out_nxt.last;
      end
      ST_FDAT: begin
        out_nxt.result_kind = 1'b1;
        case (bcnt_r)
          3'd0:    out_nxt.frame_byte = 8'(sel_r) + ID_OFFSET;
          3'd1:    out_nxt.frame_byte = delay_rdata[31:24];
          3'd2:    out_nxt.frame_byte = delay_rdata[23:16];
          3'd3:    out_nxt.frame_byte = delay_rdata[15:8];
          default: out_nxt.frame_byte = delay_rdata[7:0];
        endcase
        out_nxt.last = (bcnt_r == 3'd4) && (pend_clr == '0);
        out_load     = out_free;
        frame_end    = out_free && out_nxt.last;
      end
      ST_IDLE, ST_LEN, ST_CLS, ST_FSEL: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  // ------------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == KIND_FRAME) begin
            state_nxt = ST_FHDR;
          end else if (in_ok) begin
            state_nxt = in_data.level ? ST_EMIT : ST_LEN;
          end
        end
      end
      ST_LEN:  state_nxt = ST_CLS;
      ST_CLS:  if (cls.done) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      ST_FHDR: begin
        if (out_free && (bcnt_r == 3'd2)) begin
          state_nxt = (pend_r == '0) ? ST_IDLE : ST_FSEL;
        end
      end
      ST_FSEL: state_nxt = ST_FDAT;
      ST_FDAT: begin
        if (out_free && (bcnt_r == 3'd4)) begin
          state_nxt = (pend_clr == '0) ? ST_IDLE : ST_FSEL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ------------------------------------------------------------ item context
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
      sidx_r <= in_sidx;
    end
    if (state_r == ST_LEN) begin
      start_r <= start_val;
      delay_r <= item_r.timestamp - sync_start_r;
    end
    // rising edge: start result right away
    if (in_acc) begin
      res_r.result_kind <= 1'b0;
      res_r.pulse_type  <= PT_START;
      res_r.skip_bit    <= 1'b0;
      res_r.rotor_bit   <= 1'b0;
      res_r.data_bit    <= 1'b0;
      res_r.frame_byte  <= '0;
      res_r.last        <= 1'b1;
    end else if ((state_r == ST_CLS) && cls.done) begin
      res_r.pulse_type <= cls.ptype;
      res_r.skip_bit   <= cls.code[2];
      res_r.rotor_bit  <= cls.code[1];
      res_r.data_bit   <= cls.code[0];
    end
  end

  // frame walk counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= '0;
      pend_r <= '0;
      sel_r  <= '0;
    end else begin
      if (in_acc) begin
        bcnt_r <= '0;
        pend_r <= seen_r & nmask;
      end else if (state_r == ST_FSEL) begin
        bcnt_r <= '0;
        sel_r  <= first_idx;
      end else if (out_load && (state_r == ST_FHDR)) begin
        bcnt_r <= bcnt_r + 3'd1;
      end else if (out_load && (state_r == ST_FDAT)) begin
        bcnt_r <= bcnt_r + 3'd1;
        if (bcnt_r == 3'd4) begin
          pend_r <= pend_clr;
        end
      end
    end
  end

  // ------------------------------------------------------ persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_vld_r   <= '0;
      seen_r       <= '0;
      latest_r     <= '0;
      prev_r       <= '0;
      sync_start_r <= '0;
      armed_r      <= 1'b0;
      run_r        <= '0;
      station_r    <= 1'b0;
    end else begin
      if (in_acc && (in_data.kind == KIND_EDGE) && in_ok && in_data.level) begin
        edge_vld_r[in_sidx] <= 1'b1;
      end
      if ((state_r == ST_CLS) && cls.done) begin
        if (cls.ptype == PT_SYNC) begin
          prev_r       <= latest_r;
          latest_r     <= cls.code;
          sync_start_r <= start_r;
          armed_r      <= 1'b1;
          if (run_r != 8'hff) begin
            run_r <= run_r + 8'd1;
          end
        end else if (cls.ptype == PT_SWEEP) begin
          if (seen_r[sidx_r]) begin
            armed_r <= 1'b0;   // repeat sweep on a marked sensor disarms
          end else if (sweep_take) begin
            station_r      <= (run_r <= 8'd1);
            run_r          <= '0;
            seen_r[sidx_r] <= 1'b1;
          end
        end
      end
      if (frame_end) begin
        seen_r <= seen_r & ~nmask;
      end
    end
  end

`ifndef ASSERT_OFF
  a_cls_in_cls: assert property (@(posedge clk) disable iff (!rst_n)
    cls.done |-> (state_r == ST_CLS))
    else $error("classifier result outside the classify phase");
  a_fsel_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FSEL) |-> (pend_r != '0))
    else $error("frame sensor select with nothing pending");
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> ((seen_r & nmask) == '0))
    else $error("marks remain after frame end");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result register overwritten while stalled");
  a_pend_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FDAT) |-> pend_r[sel_r])
    else $error("frame emits a sensor that is not pending");
`endif

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the sweep pulse timing decoder: stimulus, prediction and checks.
`default_nettype none
module tb
  import spt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Run limits. The long hold keeps the output stalled long enough for the
  // decoder to back up into its input; the watchdog limit is well above the
  // hold plus the idle stretch around each register update.
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  sweep_pulse_timing_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Decoder shadow: register copies and the state the block keeps per sensor.
  // Registers start at their reset values, so the first phase runs unwritten.
  // ---------------------------------------------------------------------------
  logic [19:0] cur_base   = SYNC_BASE_RST;
  logic [15:0] cur_step   = SYNC_STEP_RST;
  logic [15:0] cur_half   = HALF_WIDTH_RST;
  logic [23:0] cur_period = SWEEP_PERIOD_RST;
  logic [3:0]  cur_count  = SENSOR_COUNT_RST;

  logic [31:0] rise_time [MAX_SENSORS_DEF] = '{default: '0};
  logic        marked    [MAX_SENSORS_DEF] = '{default: 1'b0};
  logic [31:0] sweep_dly [MAX_SENSORS_DEF] = '{default: '0};
  logic [2:0]  latest_code = '0;
  logic [2:0]  prev_code   = '0;
  logic [31:0] sync_t0     = '0;
  logic        armed       = 1'b0;
  logic [7:0]  run_cnt     = '0;
  logic        station     = 1'b0;

  in_item_t  queued_items [$];   // items waiting for the driver
  out_item_t predicted_out [$];  // results still owed by the decoder

  int items_taken     = 0;
  int results_checked = 0;
  int n_mismatch      = 0;
  int frames_req      = 0;
  int syncs_seen      = 0;
  int sweeps_stored   = 0;
  int cfg_writes      = 0;
  int queued_total    = 0;

  // Width sorting. Windows are [centre - half, centre + half), code k centred
  // at base + k*step; the first window that matches wins. Anything below the
  // lowest window edge is a sweep, everything else an outlier. Signed 64-bit
  // math keeps a negative lower edge from wrapping.
  function automatic void classify_width(input logic [31:0] w, output logic [1:0] cls,
                                         output logic [2:0] code);
    longint lw, b, st, h, c;
    lw   = w;
    b    = cur_base;
    st   = cur_step;
    h    = cur_half;
    cls  = PT_OUTLIER;
    code = '0;
    for (int k = 0; k < 8; k++) begin
      c = b + k * st;
      if (cls != PT_SYNC && lw >= c - h && lw < c + h) begin
        cls  = PT_SYNC;
        code = 3'(k);
      end
    end
    if (cls != PT_SYNC && lw < b - h) cls = PT_SWEEP;
  endfunction

  // Works out every result one accepted item must produce, in order.
  task automatic decode_item(input in_item_t it);
    out_item_t   r;
    logic [7:0]  frame_bytes [$];
    logic [31:0] width_cyc, dly, lim;
    logic [1:0]  cls;
    logic [2:0]  code;
    int          n_used;
    r = '0;
    if (it.kind == KIND_FRAME) begin
      frames_req++;
      n_used = (cur_count > MAX_SENSORS_DEF) ? MAX_SENSORS_DEF : int'(cur_count);
      frame_bytes.push_back(FRAME_MARK);
      frame_bytes.push_back(FRAME_MARK);
      frame_bytes.push_back({4'b0, station, prev_code});
      for (int i = 0; i < n_used; i++) begin
        if (marked[i]) begin
          frame_bytes.push_back(8'(i) + ID_OFFSET);
          frame_bytes.push_back(sweep_dly[i][31:24]);
          frame_bytes.push_back(sweep_dly[i][23:16]);
          frame_bytes.push_back(sweep_dly[i][15:8]);
          frame_bytes.push_back(sweep_dly[i][7:0]);
        end
      end
      for (int i = 0; i < n_used; i++) marked[i] = 1'b0;
      foreach (frame_bytes[j]) begin
        r             = '0;
        r.result_kind = 1'b1;
        r.frame_byte  = frame_bytes[j];
        r.last        = (j == frame_bytes.size() - 1);
        predicted_out.push_back(r);
      end
    end else if (it.level) begin
      rise_time[it.sensor_index] = it.timestamp;
      r.pulse_type = PT_START;
      r.last       = 1'b1;
      predicted_out.push_back(r);
    end else begin
      width_cyc = it.timestamp - rise_time[it.sensor_index];
      classify_width(width_cyc, cls, code);
      if (cls == PT_SYNC) begin
        syncs_seen++;
        prev_code   = latest_code;
        latest_code = code;
        sync_t0     = rise_time[it.sensor_index];
        armed       = 1'b1;
        if (run_cnt != 8'hff) run_cnt = run_cnt + 8'd1;
      end else if (cls == PT_SWEEP) begin
        if (!marked[it.sensor_index]) begin
          dly = it.timestamp - sync_t0;
          lim = (33'(cur_period) > ACCEPT_MARGIN) ? 32'(33'(cur_period) - ACCEPT_MARGIN)
                                                  : 32'd0;
          if (dly < lim && armed) begin
            // at most one sync since the last stored sweep marks the other station
            station                    = (run_cnt <= 8'd1);
            run_cnt                    = '0;
            sweep_dly[it.sensor_index] = dly;
            marked[it.sensor_index]    = 1'b1;
            sweeps_stored++;
          end
        end else begin
          // second sweep on a sensor already holding one disarms the sync
          armed = 1'b0;
        end
      end
      r.pulse_type = cls;
      if (cls == PT_SYNC) {r.skip_bit, r.rotor_bit, r.data_bit} = code;
      r.last = 1'b1;
      predicted_out.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; a stalled item holds.
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_item(in_data);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_items.size() != 0) begin
          in_data  <= queued_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            // a quarter of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: segments of no stall, random stall and alternating stall.
  // A long hold is served whenever the sequence asks for one.
  // ---------------------------------------------------------------------------
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int seg_left      = 0;
  int seg_mode      = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 40);
        seg_mode = $urandom_range(0, 2);
      end else begin
        seg_left--;
      end
      case (seg_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 40);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  out_item_t want_res;

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_mismatch++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (predicted_out.size() == 0) begin
        $error("result 0x%0h arrived with nothing predicted", out_data);
        n_mismatch++;
      end else begin
        want_res = predicted_out.pop_front();
        check_field("result_kind", 8'(want_res.result_kind), 8'(out_data.result_kind));
        check_field("pulse_type",  8'(want_res.pulse_type),  8'(out_data.pulse_type));
        check_field("skip_bit",    8'(want_res.skip_bit),    8'(out_data.skip_bit));
        check_field("rotor_bit",   8'(want_res.rotor_bit),   8'(out_data.rotor_bit));
        check_field("data_bit",    8'(want_res.data_bit),    8'(out_data.data_bit));
        check_field("frame_byte",  want_res.frame_byte,      out_data.frame_byte);
        check_field("last",        8'(want_res.last),        8'(out_data.last));
      end
    end
  end

  // Watchdog: too long without any handshake on either channel ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, predicted_out.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building. stamp is the running sensor clock; it wraps freely.
  // ---------------------------------------------------------------------------
  logic [31:0] stamp      = '0;
  logic [31:0] pulse_rise = '0;
  logic [31:0] sync_rise  = '0;

  task automatic push_item(input logic kind, input logic [2:0] sensor, input logic level,
                           input logic [31:0] ts);
    in_item_t it;
    it.kind         = kind;
    it.sensor_index = sensor;
    it.level        = level;
    it.timestamp    = ts;
    queued_items.push_back(it);
    queued_total++;
  endtask

  task automatic push_pulse(input logic [2:0] sensor, input logic [31:0] width);
    pulse_rise = stamp;
    push_item(KIND_EDGE, sensor, 1'b1, stamp);
    push_item(KIND_EDGE, sensor, 1'b0, stamp + width);
    stamp = stamp + width + 32'($urandom_range(1, 300));
  endtask

  task automatic push_frame();
    // sensor, level and timestamp carry no meaning on a frame request
    push_item(KIND_FRAME, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), $urandom());
  endtask

  // Width inside the window of one sync code, often right on an edge.
  function automatic logic [31:0] sync_width(input int code);
    longint b, st, h, c, lo, hi;
    b  = cur_base;
    st = cur_step;
    h  = cur_half;
    c  = b + code * st;
    lo = (c - h < 0) ? 0 : c - h;
    hi = c + h - 1;
    if (hi < lo) return 32'(c);
    case ($urandom_range(0, 3))
      0:       return 32'(lo);
      1:       return 32'(hi);
      default: return 32'(lo + $urandom_range(0, int'(hi - lo)));
    endcase
  endfunction

  // Width below the lowest window when such a width exists, sometimes the largest one.
  function automatic logic [31:0] sweep_width();
    longint b, h, top;
    b   = cur_base;
    h   = cur_half;
    top = b - h - 1;
    if (top < 0) return 32'($urandom_range(0, 2000));
    if ($urandom_range(0, 3) == 0) return 32'(top);
    return 32'($urandom_range(0, (top > 3000) ? 3000 : int'(top)));
  endfunction

  // Sweep whose delay from the last sync sits just below or on the limit.
  task automatic push_timed_sweep(input int offset);
    logic [31:0] lim, fall, w;
    logic [2:0]  s;
    lim  = (33'(cur_period) > ACCEPT_MARGIN) ? 32'(33'(cur_period) - ACCEPT_MARGIN) : 32'd0;
    w    = sweep_width();
    fall = sync_rise + lim + 32'(offset);
    s    = 3'($urandom_range(0, 7));
    push_item(KIND_EDGE, s, 1'b1, fall - w);
    push_item(KIND_EDGE, s, 1'b0, fall);
    stamp = fall + 32'($urandom_range(1, 300));
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 2))
      0:       push_item(KIND_EDGE, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         $urandom());
      1:       push_pulse(3'($urandom_range(0, 7)), 32'($urandom_range(0, 2000000)));
      default: push_frame();
    endcase
  endtask

  // One sweep round: syncs, sweeps on random sensors (repeats disarm), and
  // usually a frame request; now and then stray items in between.
  task automatic push_round();
    int nsync, nsweep;
    nsync  = $urandom_range(1, 3);
    nsweep = $urandom_range(1, 4);
    repeat (nsync) begin
      push_pulse(3'($urandom_range(0, 7)), sync_width($urandom_range(0, 7)));
      sync_rise = pulse_rise;
    end
    repeat (nsweep) begin
      if ($urandom_range(0, 4) == 0) push_timed_sweep($urandom_range(0, 1) ? -1 : 0);
      else push_pulse(3'($urandom_range(0, 7)), sweep_width());
    end
    if ($urandom_range(0, 2) != 0) push_frame();
    if ($urandom_range(0, 3) == 0) push_noise();
  endtask

  task automatic queue_rounds(input int n_items);
    int goal;
    @(negedge clk);
    goal = queued_total + n_items;
    while (queued_total < goal) push_round();
  endtask

  // Sender pause: nothing queued, nothing offered, every result back, then
  // a DRAIN_CYCLES wait for the decoder to settle.
  task automatic wait_drained();
    @(negedge clk);
    while (queued_items.size() != 0 || in_valid || predicted_out.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SYNC_BASE:    cur_base   = value[19:0];
      CFG_SYNC_STEP:    cur_step   = value[15:0];
      CFG_HALF_WIDTH:   cur_half   = value[15:0];
      CFG_SWEEP_PERIOD: cur_period = value[23:0];
      CFG_SENSOR_COUNT: cur_count  = value[3:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [19:0] base, input logic [15:0] step,
                           input logic [15:0] half, input logic [23:0] period,
                           input logic [3:0] count);
    write_reg(CFG_SYNC_BASE,    CFG_DATA_W'(base));
    write_reg(CFG_SYNC_STEP,    CFG_DATA_W'(step));
    write_reg(CFG_HALF_WIDTH,   CFG_DATA_W'(half));
    write_reg(CFG_SWEEP_PERIOD, CFG_DATA_W'(period));
    write_reg(CFG_SENSOR_COUNT, CFG_DATA_W'(count));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    stamp = $urandom();

    // Directed, at reset register values (centres 6000 + k*1000, half 500).
    @(negedge clk);
    push_pulse(3'd0, 32'd5500);          // code 0 at its lower window edge
    push_pulse(3'd7, 32'd13499);         // code 7 at its upper window edge
    sync_rise = pulse_rise;
    push_pulse(3'd3, 32'd5499);          // widest sweep, stored after two syncs
    push_pulse(3'd3, 32'd0);             // repeat sweep on a marked sensor disarms
    push_pulse(3'd5, 32'd100);           // sweep while disarmed: not stored
    push_pulse(3'd1, 32'hffff_ffff);     // falling before rising: wrapped width, outlier
    push_pulse(3'd2, 32'd13500);         // just past the top window: outlier
    push_frame();                        // one sensor in the frame
    push_frame();                        // marks cleared: header only
    push_pulse(3'd6, 32'd11000);         // code 5 centre: skip and data bits set
    sync_rise = pulse_rise;
    push_pulse(3'd0, 32'd200);           // single sync before it: other station
    push_pulse(3'd4, 32'd1);
    push_frame();                        // two sensors, lowest index first
    wait_drained();

    // Moderate random settings; a long output hold while the sender keeps
    // offering, so the decoder backs up and stalls its input.
    write_all(20'($urandom_range(2000, 20000)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 1500)), 24'($urandom_range(50000, 3000000)),
              4'($urandom_range(1, 8)));
    queue_rounds(20);
    hold_requests++;
    wait_drained();

    // Largest settings; the sensor count above eight acts as eight. The
    // timestamps start just short of wrapping.
    write_all(20'hfffff, 16'hffff, 16'hffff, 24'hffffff, 4'd15);
    stamp = 32'hffff_ffff - $urandom_range(0, 3000000);
    queue_rounds(12);
    wait_drained();

    // Degenerate settings: zero step overlaps all windows (lowest code wins),
    // base below half leaves no sweep range, the shortest period, and a zero
    // sensor count gives header-only frames.
    write_all(20'd100, 16'd0, 16'd200, 24'd10001, 4'd0);
    queue_rounds(8);
    wait_drained();

    // Random settings with fewer sensors than the maximum, and another hold.
    write_all(20'($urandom_range(2000, 20000)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 1500)), 24'($urandom_range(10001, 1000000)),
              4'($urandom_range(1, 7)));
    stamp = $urandom();
    queue_rounds(16);
    hold_requests++;
    wait_drained();

    repeat (40) @(posedge clk);
    if (predicted_out.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_out.size());
      n_mismatch++;
    end
    $display("covered %0d items, %0d results: %0d frames, %0d syncs, %0d sweeps stored",
             items_taken, results_checked, frames_req, syncs_seen, sweeps_stored);
    $display("across %0d register writes, reset, random, largest and degenerate settings",
             cfg_writes);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sweep_pulse_timing_decoder_top.f]
src/spt_pkg.sv
src/spt_ram.sv
src/spt_classifier.sv
src/sweep_pulse_timing_decoder_top.sv
bench/tb.sv
